FILE: hdl/tsd_pkg.sv
// Shared types, constants and helper functions of the triangle midpoint subdivider.
package tsd_pkg;

    localparam int EDGE_SLOTS   = 4096;
    localparam int SLOT_W       = $clog2(EDGE_SLOTS);
    localparam int MAX_VERTICES = 65536;
    localparam int ID_W         = 16;
    localparam int CNT_W        = 17;
    localparam int COORD_W      = 32;
    localparam int KEY_W        = 2 * ID_W;
    localparam int MAX_ID       = MAX_VERTICES - 1;

    localparam int EDGE_W = 2;
    localparam logic [EDGE_W-1:0] EDGE_AB = 2'd0;
    localparam logic [EDGE_W-1:0] EDGE_BC = 2'd1;
    localparam logic [EDGE_W-1:0] EDGE_CA = 2'd2;

    localparam int REC_W = 3;
    localparam logic [REC_W-1:0] REC_VERT_AB = 3'd0;
    localparam logic [REC_W-1:0] REC_VERT_BC = 3'd1;
    localparam logic [REC_W-1:0] REC_VERT_CA = 3'd2;
    localparam logic [REC_W-1:0] REC_FACE_A  = 3'd3;
    localparam logic [REC_W-1:0] REC_FACE_B  = 3'd4;
    localparam logic [REC_W-1:0] REC_FACE_C  = 3'd5;
    localparam logic [REC_W-1:0] REC_FACE_M  = 3'd6;

    localparam logic KIND_VERTEX = 1'b0;
    localparam logic KIND_FACE   = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [KEY_W-1:0]  key;
        logic [ID_W-1:0]   mid;
    } tsd_entry_t;

    typedef struct packed {
        logic              clear;
        logic              load_in;
        logic              start;
        logic [EDGE_W-1:0] edge_idx;
        logic              probe_next;
        logic              resolve;
        logic              emit;
        logic [REC_W-1:0]  rec;
    } tsd_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
        logic empty;
        logic probe_last;
        logic out_free;
        logic rec_skip;
    } tsd_status_t;

    function automatic logic [EDGE_W-1:0] tsd_next_corner(input logic [EDGE_W-1:0] e);
        logic [EDGE_W-1:0] r;
        begin
            case (e)
                EDGE_AB: r = EDGE_BC;
                EDGE_BC: r = EDGE_CA;
                default: r = EDGE_AB;
            endcase
            return r;
        end
    endfunction

    function automatic logic [COORD_W-1:0] tsd_midpoint(input logic [COORD_W-1:0] p,
                                                       input logic [COORD_W-1:0] q);
        logic [COORD_W:0] s;
        begin
            s = {p[COORD_W-1], p} + {q[COORD_W-1], q};
            return s[COORD_W:1];
        end
    endfunction

endpackage

FILE: hdl/triangle_midpoint_subdivider.sv
// Top level of the triangle midpoint subdivider.
// After reset the block sweeps its 4096-entry edge table, one entry a cycle, and takes no
// request until the sweep is done. Each triangle is then accepted in S_IDLE, and each of its
// edges AB, BC and CA is looked up through S_START, S_LOOK and S_CHECK, with S_LOOK and S_CHECK
// repeated for every extra slot probed in the edge table memory. S_EMIT then steps through
// the seven record slots, sending a result record (four to seven in all) or skipping a vertex
// slot whose midpoint was found in the table; a record that waits for the receiver holds the
// step. The single read port of the edge table sets the lookup time.
module triangle_midpoint_subdivider
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic [15:0]   cfg_wdata,    // first_new_vertex
    input  logic          s_tvalid,
    output logic          s_tready,
    // corner_a, corner_b, corner_c, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
    input  logic [335:0]  s_tdata,
    output logic          m_tvalid,
    input  logic          m_tready,
    // id_first, id_second, id_third, pos_x, pos_y, pos_z
    output logic [143:0]  m_tdata,
    output logic [1:0]    m_tuser,      // record_kind, overflow
    output logic          m_tlast
);

    tsd_pkg::tsd_cmd_t    cmd;
    tsd_pkg::tsd_status_t status;

    tsd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tsd_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata),
        .out_user  (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

FILE: hdl/tsd_datapath.sv
// Datapath: input registers, edge table memory, vertex id counter and output register.
module tsd_datapath
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  tsd_pkg::tsd_cmd_t               cmd,
    output tsd_pkg::tsd_status_t            status,
    input  logic [335:0]                    in_data,
    input  logic                            cfg_we,
    input  logic [tsd_pkg::ID_W-1:0]        cfg_wdata,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [143:0]                    out_data,
    output logic [1:0]                      out_user,
    output logic                            out_last
);

    logic [tsd_pkg::ID_W-1:0]    corner_reg [3];
    logic [tsd_pkg::COORD_W-1:0] pos_reg    [3][3];

    tsd_pkg::tsd_entry_t         mem [tsd_pkg::EDGE_SLOTS];
    tsd_pkg::tsd_entry_t         rd_reg;
    logic                        mem_we;
    logic [tsd_pkg::SLOT_W-1:0]  mem_waddr;
    tsd_pkg::tsd_entry_t         mem_wdata;

    logic [tsd_pkg::SLOT_W-1:0]  clear_idx_reg;
    logic [tsd_pkg::SLOT_W-1:0]  probe_idx_reg;
    logic [tsd_pkg::SLOT_W-1:0]  probe_cnt_reg;
    logic [tsd_pkg::KEY_W-1:0]   key_reg;
    logic [tsd_pkg::CNT_W-1:0]   next_id_reg;
    logic [tsd_pkg::CNT_W-1:0]   next_id_next;
    logic [tsd_pkg::ID_W-1:0]    mid_reg    [3];
    logic [2:0]                  is_new_reg;
    logic                        ovf_reg;

    logic                        out_valid_reg;
    logic [143:0]                out_data_reg;
    logic                        out_kind_reg;
    logic                        out_ovf_reg;
    logic                        out_last_reg;

    logic [tsd_pkg::ID_W-1:0]    u_id;
    logic [tsd_pkg::ID_W-1:0]    v_id;
    logic [tsd_pkg::KEY_W-1:0]   new_key;
    logic                        ids_out;
    logic [tsd_pkg::ID_W-1:0]    alloc_mid;
    logic                        load_out;
    logic [tsd_pkg::EDGE_W-1:0]  vp;
    logic [tsd_pkg::EDGE_W-1:0]  vq;
    logic [143:0]                rec_data;
    logic                        rec_kind;
    logic                        rec_last;

    always_comb
    begin
        u_id    = corner_reg[cmd.edge_idx];
        v_id    = corner_reg[tsd_pkg::tsd_next_corner(cmd.edge_idx)];
        new_key = (u_id < v_id) ? {u_id, v_id} : {v_id, u_id};
    end

    assign ids_out   = next_id_reg >= tsd_pkg::CNT_W'(tsd_pkg::MAX_VERTICES);
    assign alloc_mid = ids_out ? tsd_pkg::ID_W'(tsd_pkg::MAX_ID)
                               : next_id_reg[tsd_pkg::ID_W-1:0];

    assign status.clear_last = &clear_idx_reg;
    assign status.hit        = rd_reg.valid && (rd_reg.key == key_reg);
    assign status.empty      = !rd_reg.valid;
    assign status.probe_last = &probe_cnt_reg;
    assign status.out_free   = !out_valid_reg || out_ready;
    assign status.rec_skip   = (cmd.rec <= tsd_pkg::REC_VERT_CA)
                               && !is_new_reg[cmd.rec[1:0]];

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = probe_idx_reg;
        mem_wdata = '{valid: 1'b1, key: key_reg, mid: alloc_mid};
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clear_idx_reg;
            mem_wdata = '0;
        end
        else if (cmd.resolve && !status.hit && !ids_out && status.empty)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= mem[probe_idx_reg];
    end

    always_comb
    begin
        next_id_next = next_id_reg;
        if (cfg_we)
        begin
            next_id_next = {1'b0, cfg_wdata};
        end
        else if (cmd.resolve && !status.hit && !ids_out)
        begin
            next_id_next = next_id_reg + tsd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_idx_reg <= '0;
            next_id_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear)
            begin
                clear_idx_reg <= clear_idx_reg + tsd_pkg::SLOT_W'(1);
            end
            next_id_reg <= next_id_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            for (int i = 0; i < 3; i++)
            begin
                corner_reg[i] <= in_data[16*i +: 16];
                for (int j = 0; j < 3; j++)
                begin
                    pos_reg[i][j] <= in_data[48 + 96*i + 32*j +: 32];
                end
            end
            ovf_reg    <= 1'b0;
            is_new_reg <= '0;
        end
        if (cmd.start)
        begin
            key_reg       <= new_key;
            probe_idx_reg <= new_key[tsd_pkg::SLOT_W-1:0];
            probe_cnt_reg <= '0;
        end
        if (cmd.probe_next)
        begin
            probe_idx_reg <= probe_idx_reg + tsd_pkg::SLOT_W'(1);
            probe_cnt_reg <= probe_cnt_reg + tsd_pkg::SLOT_W'(1);
        end
        if (cmd.resolve)
        begin
            if (status.hit)
            begin
                mid_reg[cmd.edge_idx] <= rd_reg.mid;
            end
            else
            begin
                mid_reg[cmd.edge_idx]    <= alloc_mid;
                is_new_reg[cmd.edge_idx] <= 1'b1;
                if (ids_out || !status.empty)
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
        if (load_out)
        begin
            out_data_reg <= rec_data;
            out_kind_reg <= rec_kind;
            out_last_reg <= rec_last;
            out_ovf_reg  <= ovf_reg;
        end
    end

    assign load_out = cmd.emit && !status.rec_skip && status.out_free;
    assign vp       = cmd.rec[1:0];
    assign vq       = tsd_pkg::tsd_next_corner(cmd.rec[1:0]);

    always_comb
    begin
        rec_kind = tsd_pkg::KIND_FACE;
        rec_last = 1'b0;
        rec_data = '0;
        case (cmd.rec)
            tsd_pkg::REC_VERT_AB, tsd_pkg::REC_VERT_BC, tsd_pkg::REC_VERT_CA:
            begin
                rec_kind = tsd_pkg::KIND_VERTEX;
                rec_data = {tsd_pkg::tsd_midpoint(pos_reg[vp][2], pos_reg[vq][2]),
                            tsd_pkg::tsd_midpoint(pos_reg[vp][1], pos_reg[vq][1]),
                            tsd_pkg::tsd_midpoint(pos_reg[vp][0], pos_reg[vq][0]),
                            32'd0, mid_reg[vp]};
            end
            tsd_pkg::REC_FACE_A:
            begin
                rec_data = {96'd0, mid_reg[2], mid_reg[0], corner_reg[0]};
            end
            tsd_pkg::REC_FACE_B:
            begin
                rec_data = {96'd0, mid_reg[1], corner_reg[1], mid_reg[0]};
            end
            tsd_pkg::REC_FACE_C:
            begin
                rec_data = {96'd0, corner_reg[2], mid_reg[1], mid_reg[2]};
            end
            default:
            begin
                rec_data = {96'd0, mid_reg[2], mid_reg[1], mid_reg[0]};
                rec_last = 1'b1;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_user  = {out_ovf_reg, out_kind_reg};
    assign out_last  = out_last_reg;

    a_id_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (!cfg_we && !cmd.clear) |=> next_id_reg >= $past(next_id_reg))
        else $error("vertex id counter went backwards");

    a_last_is_face: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> out_kind_reg == tsd_pkg::KIND_FACE)
        else $error("last request is not a sub-face");

    a_no_write_when_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.resolve && status.hit) |-> !mem_we)
        else $error("edge table written on a hit");

endmodule

FILE: hdl/tsd_ctrl.sv
// Controller: sequences the table clearing, the lookups of edges AB, BC and CA and the record output.
module tsd_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tsd_pkg::tsd_status_t  status,
    output tsd_pkg::tsd_cmd_t     cmd
);

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_START = 6'b000100,
        S_LOOK  = 6'b001000,
        S_CHECK = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t                     state_reg, state_next;
    logic [tsd_pkg::EDGE_W-1:0] edge_reg, edge_next;
    logic [tsd_pkg::REC_W-1:0]  rec_reg, rec_next;

    always_comb
    begin
        state_next = state_reg;
        edge_next  = edge_reg;
        rec_next   = rec_reg;
        cmd        = '0;
        cmd.edge_idx = edge_reg;
        cmd.rec      = rec_reg;
        in_ready   = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    edge_next   = tsd_pkg::EDGE_AB;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                cmd.start  = 1'b1;
                state_next = S_LOOK;
            end
            S_LOOK:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (status.hit || status.empty || status.probe_last)
                begin
                    cmd.resolve = 1'b1;
                    if (edge_reg == tsd_pkg::EDGE_CA)
                    begin
                        rec_next   = tsd_pkg::REC_VERT_AB;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        edge_next  = tsd_pkg::tsd_next_corner(edge_reg);
                        state_next = S_START;
                    end
                end
                else
                begin
                    cmd.probe_next = 1'b1;
                    state_next     = S_LOOK;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (status.rec_skip || status.out_free)
                begin
                    rec_next = rec_reg + tsd_pkg::REC_W'(1);
                    if (rec_reg == tsd_pkg::REC_FACE_M)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            edge_reg  <= '0;
            rec_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            edge_reg  <= edge_next;
            rec_reg   <= rec_next;
        end
    end

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_in |=> state_reg == S_START)
        else $error("accepted request did not start a lookup");

    a_rec_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> rec_reg <= tsd_pkg::REC_FACE_M)
        else $error("record index out of range");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR || state_reg == S_EMIT) |-> !in_ready)
        else $error("request accepted while busy");

endmodule
